>>> rtl/core/tbrl_pkg.sv
`timescale 1ns / 1ps
// Package for the token bucket rate limiter: field widths, codes and the
// request and response transaction structs. It depends on nothing else.
package tbrl_pkg;

   localparam int RATE_W       = 48;
   localparam int BURST_W      = 16;
   localparam int TS_W         = 64;
   localparam int COST_W       = 32;
   localparam int WAIT_W       = 32;
   localparam int TOK_W        = 32;

   localparam int DEFAULT_TOKEN_FRAC_BITS = 16;

   // The multiplier takes one 16-bit digit of its second operand per step.
   localparam int MUL_DIGIT_W  = 16;

   // Nanoseconds per millisecond, held as a 32-bit operand for the multiplier.
   localparam int NS_OP_W      = 32;
   localparam int NS_PER_MS_W  = 20;
   localparam logic [NS_OP_W-1:0] NS_PER_MS = 32'd1000000;

   localparam int CSR_INDEX_W  = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_RATE  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BURST = 2'd1;

   localparam logic REQ_ALLOW = 1'b0;
   localparam logic REQ_WAIT  = 1'b1;

   localparam logic [BURST_W-1:0] BURST_RESET = 16'd1;

   typedef struct packed {
      logic               req_type;
      logic [TS_W-1:0]    timestamp_ns;
      logic [COST_W-1:0]  cost_q16;
   } req_payload_type;

   typedef struct packed {
      logic               granted;
      logic [WAIT_W-1:0]  wait_ms;
      logic [TOK_W-1:0]   tokens_left_q16;
   } rsp_payload_type;

endpackage

>>> rtl/core/token_bucket_rate_limiter_core.sv
`timescale 1ns / 1ps
// Token bucket rate limiter core: sequencer around one shared adder and a
// 48x16 multiplier. Depends on tbrl_pkg for widths, codes and payload structs.
//
// One request transaction is worked on at a time and yields one response
// transaction. An allow request runs four multiply steps for rate times
// elapsed time, then refill and grant. A wait query that is affordable at
// once or meets a zero rate goes straight to the response; any other one
// multiplies out the divisor and, unless the quotient saturates, runs the 32
// quotient steps of the restoring divider that shares the adder with the
// multiplier, then a rounding step. A finished response waits in an output
// register, so the next request is taken while it has not yet been collected.
// The first request after reset fills the bucket to burst. Configuration writes
// are taken in every cycle and must only be made while the block is idle.
module token_bucket_rate_limiter_core #(
   parameter int TOKEN_FRAC_BITS = tbrl_pkg::DEFAULT_TOKEN_FRAC_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  tbrl_pkg::req_payload_type           req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output tbrl_pkg::rsp_payload_type           rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [tbrl_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [tbrl_pkg::RATE_W-1:0]         csr_wdata
);
   import tbrl_pkg::*;

   localparam int RATE_SHIFT = RATE_W - TOKEN_FRAC_BITS;
   localparam int ACC_W      = RATE_W + TS_W;
   localparam int NUM_W      = COST_W + RATE_SHIFT;
   localparam int DEN_W      = RATE_W + NS_PER_MS_W;
   localparam int CAP_W      = BURST_W + TOKEN_FRAC_BITS;
   localparam int CAP_X_W    = (CAP_W > TOK_W + 1) ? CAP_W : TOK_W + 1;
   localparam int MUL_STEPS  = TS_W / MUL_DIGIT_W;
   localparam int MS_STEPS   = NS_OP_W / MUL_DIGIT_W;
   localparam int CNT_W      = $clog2(WAIT_W);
   localparam int PROD_W     = RATE_W + MUL_DIGIT_W;

   typedef enum logic [8:0] {
      ST_IDLE   = 9'b000000001,
      ST_PREP   = 9'b000000010,
      ST_MUL    = 9'b000000100,
      ST_REFILL = 9'b000001000,
      ST_GRANT  = 9'b000010000,
      ST_DSET   = 9'b000100000,
      ST_DIV    = 9'b001000000,
      ST_ROUND  = 9'b010000000,
      ST_DONE   = 9'b100000000
   } state_type;

   state_type             state_ff, state_in;
   logic                  primed_ff, primed_in;
   logic [RATE_W-1:0]     rate_ff, rate_in;
   logic [BURST_W-1:0]    burst_ff, burst_in;
   logic [TOK_W-1:0]      token_ff, token_in;
   logic [TS_W-1:0]       last_time_ff, last_time_in;
   req_payload_type       req_ff, req_in;
   logic [ACC_W-1:0]      acc_ff, acc_in;
   logic [TS_W-1:0]       mop_ff, mop_in;
   logic [DEN_W-1:0]      den_ff, den_in;
   logic [COST_W-1:0]     need_ff, need_in;
   logic [WAIT_W-1:0]     numlo_ff, numlo_in;
   logic [WAIT_W-1:0]     wait_ff, wait_in;
   logic                  granted_ff, granted_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_payload_type       rsp_data_ff, rsp_data_in;

   logic [BURST_W-1:0]    burst_eff;
   logic [CAP_W-1:0]      cap_wide;
   logic [CAP_X_W-1:0]    cap_ext;
   logic [TOK_W-1:0]      cap;
   logic [PROD_W-1:0]     mul_prod;
   logic [ACC_W-1:0]      add_a, add_b;
   logic                  add_cin;
   logic [ACC_W:0]        add_sum;
   logic                  add_ge;
   logic                  add_hi_any;
   logic [TOK_W-1:0]      add32;
   logic [TOK_W:0]        refill_sum;
   logic [NUM_W-1:0]      num;
   logic [DEN_W-1:0]      den_now;
   logic [DEN_W-1:0]      div_top;
   logic                  rsp_free;

   // Bucket capacity in token units, saturating at the token register width.
   always_comb begin
      burst_eff = (burst_ff == '0) ? BURST_RESET : burst_ff;
      cap_wide  = {burst_eff, {TOKEN_FRAC_BITS{1'b0}}};
      cap_ext   = CAP_X_W'(cap_wide);
      cap       = (|cap_ext[CAP_X_W-1:TOK_W]) ? '1 : cap_ext[TOK_W-1:0];
   end

   assign mul_prod = rate_ff * mop_ff[TS_W-1 -: MUL_DIGIT_W];

   // Shared adder: shift-and-accumulate for the multiplier, trial subtract
   // of the divisor for the divider and the rounding test.
   always_comb begin
      if (state_ff == ST_MUL) begin
         add_a   = {acc_ff[ACC_W-MUL_DIGIT_W-1:0], {MUL_DIGIT_W{1'b0}}};
         add_b   = ACC_W'(mul_prod);
         add_cin = 1'b0;
      end else begin
         add_a   = {acc_ff[ACC_W-2:0],
                    (state_ff == ST_DIV) ? numlo_ff[WAIT_W-1] : 1'b0};
         add_b   = ~ACC_W'(den_ff);
         add_cin = 1'b1;
      end
      add_sum = {1'b0, add_a} + {1'b0, add_b} + {{ACC_W{1'b0}}, add_cin};
      add_ge  = add_sum[ACC_W];
   end

   always_comb begin
      add_hi_any = |acc_ff[ACC_W-1:RATE_SHIFT+TOK_W];
      add32      = acc_ff[RATE_SHIFT+TOK_W-1:RATE_SHIFT];
      refill_sum = {1'b0, token_ff} + {1'b0, add32};
      num        = {need_ff, {RATE_SHIFT{1'b0}}};
      den_now    = acc_ff[DEN_W-1:0];
      div_top    = DEN_W'(num[NUM_W-1:WAIT_W]);
      rsp_free   = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      state_in     = state_ff;
      primed_in    = primed_ff;
      rate_in      = rate_ff;
      burst_in     = burst_ff;
      token_in     = token_ff;
      last_time_in = last_time_ff;
      req_in       = req_ff;
      acc_in       = acc_ff;
      mop_in       = mop_ff;
      den_in       = den_ff;
      need_in      = need_ff;
      numlo_in     = numlo_ff;
      wait_in      = wait_ff;
      granted_in   = granted_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_ready ? 1'b0 : rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (csr_valid) begin
         case (csr_index)
            CSR_RATE:  rate_in  = csr_wdata;
            CSR_BURST: burst_in = csr_wdata[BURST_W-1:0];
            default:   ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in = req_data;
               // The first transaction after reset starts with a full bucket.
               if (!primed_ff) begin
                  token_in     = cap;
                  last_time_in = req_data.timestamp_ns;
                  primed_in    = 1'b1;
               end
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            granted_in = 1'b0;
            wait_in    = '0;
            acc_in     = '0;
            if (req_ff.req_type == REQ_ALLOW) begin
               mop_in   = req_ff.timestamp_ns - last_time_ff;
               cnt_in   = CNT_W'(MUL_STEPS - 1);
               state_in = ST_MUL;
            end else if (token_ff >= req_ff.cost_q16) begin
               state_in = ST_DONE;
            end else if (rate_ff == '0) begin
               wait_in  = '1;
               state_in = ST_DONE;
            end else begin
               need_in  = req_ff.cost_q16 - token_ff;
               mop_in   = {NS_PER_MS, {(TS_W-NS_OP_W){1'b0}}};
               cnt_in   = CNT_W'(MS_STEPS - 1);
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            acc_in = add_sum[ACC_W-1:0];
            mop_in = {mop_ff[TS_W-MUL_DIGIT_W-1:0], {MUL_DIGIT_W{1'b0}}};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = (req_ff.req_type == REQ_ALLOW) ? ST_REFILL : ST_DSET;
            end
         end
         ST_REFILL: begin
            if (add_hi_any || add32 >= cap) begin
               token_in = cap;
            end else if (refill_sum > {1'b0, cap}) begin
               token_in = cap;
            end else begin
               token_in = refill_sum[TOK_W-1:0];
            end
            last_time_in = req_ff.timestamp_ns;
            state_in     = ST_GRANT;
         end
         ST_GRANT: begin
            if (token_ff >= req_ff.cost_q16) begin
               token_in   = token_ff - req_ff.cost_q16;
               granted_in = 1'b1;
            end
            state_in = ST_DONE;
         end
         ST_DSET: begin
            // When the upper part of the dividend already reaches the divisor
            // the quotient cannot fit in 32 bits and the answer saturates.
            den_in   = den_now;
            acc_in   = ACC_W'(div_top);
            numlo_in = num[WAIT_W-1:0];
            cnt_in   = CNT_W'(WAIT_W - 1);
            if (div_top >= den_now) begin
               wait_in  = '1;
               state_in = ST_DONE;
            end else begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            acc_in   = add_ge ? add_sum[ACC_W-1:0] : add_a;
            wait_in  = {wait_ff[WAIT_W-2:0], add_ge};
            numlo_in = {numlo_ff[WAIT_W-2:0], 1'b0};
            cnt_in   = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            // Round half up: twice the remainder against the divisor.
            if (add_ge && !(&wait_ff)) begin
               wait_in = wait_ff + 1'b1;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in                = 1'b1;
               rsp_data_in.granted         = granted_ff;
               rsp_data_in.wait_ms         = wait_ff;
               rsp_data_in.tokens_left_q16 = token_ff;
               state_in                    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         primed_ff    <= 1'b0;
         rate_ff      <= '0;
         burst_ff     <= BURST_RESET;
         token_ff     <= '0;
         last_time_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         primed_ff    <= primed_in;
         rate_ff      <= rate_in;
         burst_ff     <= burst_in;
         token_ff     <= token_in;
         last_time_ff <= last_time_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      acc_ff      <= acc_in;
      mop_ff      <= mop_in;
      den_ff      <= den_in;
      need_ff     <= need_in;
      numlo_ff    <= numlo_in;
      wait_ff     <= wait_in;
      granted_ff  <= granted_in;
      cnt_ff      <= cnt_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign csr_ready = 1'b1;

endmodule

>>> tb/sv/tbrl_bucket_checker.sv
`timescale 1ns / 1ps
// Checker for the token bucket rate limiter: follows the request, response and
// register channels, predicts every response and compares it field by field.
// Depends on tbrl_pkg for the payload structs, register indexes and codes.
module tbrl_bucket_checker #(
   parameter int TOKEN_FRAC_BITS = tbrl_pkg::DEFAULT_TOKEN_FRAC_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_ready,
   input  tbrl_pkg::req_payload_type         req_data,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  tbrl_pkg::rsp_payload_type         rsp_data,
   input  logic                              csr_valid,
   input  logic                              csr_ready,
   input  logic [tbrl_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [tbrl_pkg::RATE_W-1:0]       csr_wdata,
   output int                                mismatches,
   output int                                outstanding
);
   import tbrl_pkg::*;

   localparam int RATE_SHIFT = RATE_W - TOKEN_FRAC_BITS;
   localparam logic [31:0] ALL_ONES = '1;

   logic [RATE_W-1:0]  rate_cfg;
   logic [BURST_W-1:0] burst_cfg;
   logic [TOK_W-1:0]   tokens;
   logic [TS_W-1:0]    last_ns;
   logic               primed;
   rsp_payload_type    answers_due[$];
   rsp_payload_type    due;

   function automatic logic [TOK_W-1:0] bucket_capacity();
      logic [63:0] whole;
      logic [63:0] full;
      whole = (burst_cfg == '0) ? 64'd1 : 64'(burst_cfg);
      full  = whole << TOKEN_FRAC_BITS;
      return (full > 64'(ALL_ONES)) ? ALL_ONES : full[TOK_W-1:0];
   endfunction

   // The elapsed time wraps modulo 2^64, so a timestamp that goes backwards
   // looks like a very long gap and, at a non-zero rate, fills the bucket.
   function automatic void refill(input logic [TS_W-1:0] now_ns);
      logic [TS_W-1:0]  elapsed;
      logic [111:0]     product;
      logic [111:0]     total;
      logic [TOK_W-1:0] cap;
      cap     = bucket_capacity();
      elapsed = now_ns - last_ns;
      product = 112'(rate_cfg) * 112'(elapsed);
      total   = (product >> RATE_SHIFT) + 112'(tokens);
      last_ns = now_ns;
      tokens  = (total > 112'(cap)) ? cap : total[TOK_W-1:0];
   endfunction

   function automatic logic [WAIT_W-1:0] wait_ms_for(input logic [COST_W-1:0] cost);
      logic [COST_W-1:0] short_q16;
      logic [127:0]      numer;
      logic [127:0]      denom;
      logic [127:0]      quot;
      logic [127:0]      remn;
      if (tokens >= cost) return '0;
      if (rate_cfg == '0) return ALL_ONES;
      short_q16 = cost - tokens;
      numer = 128'(short_q16) << RATE_SHIFT;
      denom = 128'(rate_cfg) * 128'(NS_PER_MS);
      quot  = numer / denom;
      remn  = numer % denom;
      // Round half up.
      if ((remn << 1) >= denom) quot = quot + 128'd1;
      return (quot > 128'(ALL_ONES)) ? ALL_ONES : quot[WAIT_W-1:0];
   endfunction

   function automatic rsp_payload_type bucket_step(input req_payload_type item);
      rsp_payload_type answer;
      answer = '0;
      // The first transaction after reset starts from a full bucket.
      if (!primed) begin
         tokens  = bucket_capacity();
         last_ns = item.timestamp_ns;
         primed  = 1'b1;
      end
      if (item.req_type == REQ_ALLOW) begin
         refill(item.timestamp_ns);
         if (tokens >= item.cost_q16) begin
            tokens = tokens - item.cost_q16;
            answer.granted = 1'b1;
         end
      end else begin
         answer.wait_ms = wait_ms_for(item.cost_q16);
      end
      answer.tokens_left_q16 = tokens;
      return answer;
   endfunction

   function automatic void report_field(input string field, input logic [63:0] want,
                                        input logic [63:0] got);
      if (want !== got) begin
         $display("%0t ns: %s mismatch, expected %0d (0x%h), got %0d (0x%h)",
                  $time, field, want, want, got, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rate_cfg    = '0;
         burst_cfg   = BURST_RESET;
         tokens      = '0;
         last_ns     = '0;
         primed      = 1'b0;
         mismatches  = 0;
         answers_due.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_RATE:  rate_cfg  = csr_wdata;
               CSR_BURST: burst_cfg = csr_wdata[BURST_W-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (answers_due.size() == 0) begin
               $display("%0t ns: response with no request outstanding, expected none, got %h",
                        $time, rsp_data);
               mismatches++;
            end else begin
               due = answers_due.pop_front();
               report_field("granted", due.granted, rsp_data.granted);
               report_field("wait_ms", due.wait_ms, rsp_data.wait_ms);
               report_field("tokens_left_q16", due.tokens_left_q16, rsp_data.tokens_left_q16);
            end
         end
         if (req_valid && req_ready) answers_due.push_back(bucket_step(req_data));
      end
      outstanding = answers_due.size();
   end

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Testbench top for the token bucket rate limiter: clock, reset, request and
// register stimulus, response back-pressure, watchdog and verdict.
// Depends on tbrl_pkg, token_bucket_rate_limiter_core and tbrl_bucket_checker.
module tb_top;
   import tbrl_pkg::*;

   localparam int IDLE_PCT        = 19;
   localparam int PHASES          = 8;
   localparam int ITEMS_PER_PHASE = 135;
   localparam int RSP_HOLD_CYCLES = 300;
   localparam int QUIET_LIMIT     = 5000;
   localparam int SETTLE_CYCLES   = 60;
   localparam int FRAC_BITS       = DEFAULT_TOKEN_FRAC_BITS;
   localparam logic [TS_W-1:0] LATE_NS = 64'h8000_0000_0000_0000;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   req_payload_type        req_data;
   logic                   rsp_valid;
   logic                   rsp_ready;
   rsp_payload_type        rsp_data;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [RATE_W-1:0]      csr_wdata;
   int                     mismatches;
   int                     outstanding;

   logic                   steady_flow;
   int                     hold_asked;
   int                     hold_served;
   int                     hold_left;
   int                     quiet_cycles;
   logic [TS_W-1:0]        now_ns;
   logic [BURST_W-1:0]     burst_now;
   logic [RATE_W-1:0]      rate_sel;
   logic [BURST_W-1:0]     burst_sel;

   token_bucket_rate_limiter_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   tbrl_bucket_checker bucket_check (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Response side: random back-pressure, plus a long hold when one is asked for.
   initial begin
      rsp_ready   = 1'b0;
      hold_served = 0;
      hold_left   = 0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else if (hold_asked != hold_served) begin
            hold_served = hold_asked;
            hold_left   = RSP_HOLD_CYCLES - 1;
            rsp_ready  <= 1'b0;
         end else begin
            rsp_ready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("token_bucket_rate_limiter_core test failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Called at a falling edge; returns at the falling edge after the transaction,
   // with valid still high so that a following request need not drop it first.
   task automatic send_req(input logic kind, input logic [TS_W-1:0] stamp,
                           input logic [COST_W-1:0] cost);
      while (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{req_type: kind, timestamp_ns: stamp, cost_q16: cost};
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [RATE_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic configure(input logic [RATE_W-1:0] rate, input logic [BURST_W-1:0] burst);
      drain();
      write_csr(CSR_RATE, rate);
      write_csr(CSR_BURST, 48'(burst));
      burst_now = burst;
   endtask

   // Mostly small forward steps in time, with some long jumps, some steps
   // backwards and some arbitrary timestamps; costs mostly lie at or below the capacity.
   task automatic send_random_req();
      logic [COST_W-1:0] cap;
      logic [COST_W-1:0] cost;
      int                pick;
      cap  = ((burst_now == '0) ? 32'd1 : 32'(burst_now)) << FRAC_BITS;
      pick = $urandom_range(99);
      if (pick < 55)      now_ns = now_ns + 64'($urandom_range(0, 3000));
      else if (pick < 80) now_ns = now_ns + 64'($urandom_range(0, 2000000));
      else if (pick < 88) now_ns = now_ns + ({$urandom, $urandom} >> $urandom_range(0, 63));
      else if (pick < 94) now_ns = now_ns - 64'($urandom_range(1, 5000));
      else                now_ns = {$urandom, $urandom};
      pick = $urandom_range(99);
      if (pick < 45)      cost = $urandom_range(0, cap / 4);
      else if (pick < 65) cost = $urandom_range(0, cap);
      else if (pick < 78) cost = 32'($urandom_range(0, 3)) << FRAC_BITS;
      else if (pick < 92) cost = $urandom;
      else if (pick < 95) cost = cap;
      else if (pick < 98) cost = '0;
      else                cost = '1;
      send_req(($urandom_range(99) < 30) ? REQ_WAIT : REQ_ALLOW, now_ns, cost);
   endtask

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      csr_valid   = 1'b0;
      csr_index   = '0;
      csr_wdata   = '0;
      steady_flow = 1'b0;
      hold_asked  = 0;
      now_ns      = '0;
      burst_now   = BURST_RESET;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset settings: zero rate, one-token bucket, filled by the first transaction.
      send_req(REQ_ALLOW, 64'd0, 32'h0001_0000);
      send_req(REQ_WAIT, 64'd10, 32'd1);
      send_req(REQ_WAIT, 64'd10, 32'd0);
      send_req(REQ_ALLOW, 64'd20, 32'd0);

      // Fastest rate with a burst of zero, which counts as one token.
      configure('1, '0);
      send_req(REQ_ALLOW, '1, '1);
      send_req(REQ_ALLOW, 64'd5, 32'h0001_0000);
      send_req(REQ_WAIT, 64'd5, '1);

      // About one token per millisecond and the largest bucket.
      configure(48'd281474976, 16'hFFFF);
      send_req(REQ_ALLOW, 64'd0, 32'hFFFF_0000);
      send_req(REQ_WAIT, 64'd0, 32'h0001_8000);
      send_req(REQ_ALLOW, 64'd1000000, 32'h0000_8000);
      send_req(REQ_ALLOW, 64'd1000000, '1);
      send_req(REQ_WAIT, 64'd1000000, 32'h8000_0000);

      // The slowest non-zero rate: long waits saturate.
      configure(48'd1, 16'hFFFF);
      send_req(REQ_WAIT, 64'd1000000, '1);
      send_req(REQ_ALLOW, LATE_NS, 32'd0);

      // A smaller burst leaves the count alone until the next allow refills it.
      configure(48'h4000_0000_0000, 16'd2);
      send_req(REQ_WAIT, LATE_NS, 32'h0002_0000);
      send_req(REQ_ALLOW, LATE_NS, 32'd0);
      send_req(REQ_ALLOW, LATE_NS + 64'd1, 32'h0002_0000);
      send_req(REQ_WAIT, LATE_NS + 64'd1, 32'd1);
      now_ns = LATE_NS + 64'd1;

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin
               rate_sel  = '1;
               burst_sel = 16'hFFFF;
            end
            1: begin
               rate_sel  = '0;
               burst_sel = 16'($urandom_range(0, 65535));
            end
            2: begin
               rate_sel  = 48'd1;
               burst_sel = 16'd1;
            end
            default: begin
               rate_sel  = 48'({$urandom, $urandom} >> $urandom_range(16, 56));
               burst_sel = 16'($urandom_range(0, 65535) >> $urandom_range(0, 15));
            end
         endcase
         configure(rate_sel, burst_sel);
         steady_flow = (phase == 3);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (phase == 5 && n == 40) hold_asked++;
            if (phase == 6 && n == 60) drain();
            send_random_req();
         end
      end
      steady_flow = 1'b0;

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("token_bucket_rate_limiter_core test passed");
      end else begin
         $display("token_bucket_rate_limiter_core test failed");
      end
      $finish;
   end

endmodule

>>> token_bucket_rate_limiter_core.f
rtl/core/tbrl_pkg.sv
rtl/core/token_bucket_rate_limiter_core.sv
tb/sv/tbrl_bucket_checker.sv
tb/sv/tb_top.sv
